>>> hw/rtl/arpc_pkg.sv
package arpc_pkg;

	localparam int ENTRIES       = 16;
	localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MIN_FRAME_LEN = 42;
	localparam int ADDR_W        = 4;

	localparam logic [15:0] PROTO_IPV4   = 16'h0800;
	localparam logic [15:0] OPER_REQUEST = 16'd1;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic start;
		logic step;
		logic write;
		logic load;
	} arpc_cmd_t;

	typedef struct packed {
		logic drop;
		logic packet;
		logic scan_done;
		logic out_free;
	} arpc_sts_t;

endpackage

>>> hw/rtl/arpc_ctrl.sv
module arpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  arpc_pkg::arpc_sts_t sts,
	output arpc_pkg::arpc_cmd_t cmd
);
	import arpc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.drop ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.packet ? ST_WRITE : ST_FIN;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/arpc_dp.sv
module arpc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  arpc_pkg::arpc_cmd_t        cmd,
	output arpc_pkg::arpc_sts_t        sts,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	input  logic                       opcode,
	input  logic [31:0]                query_ip,
	input  logic [15:0]                frame_len,
	input  logic [15:0]                proto_type,
	input  logic [15:0]                arp_oper,
	input  logic [31:0]                sender_ip,
	input  logic [47:0]                sender_mac,
	input  logic [31:0]                target_ip,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [47:0]                found_mac,
	output logic                       packet_ok,
	output logic                       reply_send,
	output logic [47:0]                reply_dest_mac,
	output logic [31:0]                reply_target_ip
);
	import arpc_pkg::*;

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	logic [31:0] entry_ip_q  [ENTRIES];
	logic [47:0] entry_mac_q [ENTRIES];
	logic [ENTRIES-1:0] entry_valid_q;

	logic        opcode_q;
	logic        ok_q;
	logic [31:0] key_q;
	logic [47:0] smac_q;
	logic [31:0] tip_q;
	logic [15:0] oper_q;

	idx_t        idx_q;
	logic        hit_q;
	idx_t        hit_idx_q;
	logic [47:0] hit_mac_q;
	logic        free_q;
	idx_t        free_idx_q;

	logic        out_valid_q;
	logic        found_q;
	logic [47:0] found_mac_q;
	logic        packet_ok_q;
	logic        reply_send_q;
	logic [47:0] reply_dest_mac_q;
	logic [31:0] reply_target_ip_q;

	logic        pass_in;
	logic        match_now;
	logic        last_now;
	logic        reply_d;
	logic        cfg_wr;
	idx_t        wr_idx;

	assign pass_in   = (frame_len >= 16'(MIN_FRAME_LEN)) && (proto_type == PROTO_IPV4);
	assign match_now = entry_valid_q[idx_q] && (entry_ip_q[idx_q] == key_q);
	assign last_now  = (idx_q == IDX_W'(ENTRIES - 1));
	assign reply_d   = ok_q && (oper_q == OPER_REQUEST) && (tip_q == own_ip_q);
	assign cfg_wr    = psel && penable && pwrite;
	assign wr_idx    = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);

	assign sts.drop      = (opcode == OP_PACKET) && !pass_in;
	assign sts.packet    = (opcode_q == OP_PACKET);
	assign sts.scan_done = match_now || last_now;
	assign sts.out_free  = !out_valid_q || out_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_OWN_IP:  own_ip_q  <= pwdata[31:0];
				REG_OWN_MAC: own_mac_q <= pwdata[47:0];
				default:     own_ip_q  <= own_ip_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_OWN_IP:  prdata = {32'd0, own_ip_q};
			REG_OWN_MAC: prdata = {16'd0, own_mac_q};
			default:     prdata = '0;
		endcase
	end

	// control state of the scan, the table valid marks and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				idx_q  <= '0;
			end else if (cmd.step) begin
				if (match_now) begin
					hit_q <= 1'b1;
				end
				if (!entry_valid_q[idx_q] && !free_q) begin
					free_q <= 1'b1;
				end
				if (!last_now) begin
					idx_q <= idx_q + idx_t'(1);
				end
			end
			if (cmd.write) begin
				entry_valid_q[wr_idx] <= 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			opcode_q <= opcode;
			ok_q     <= (opcode == OP_PACKET) && pass_in;
			key_q    <= (opcode == OP_PACKET) ? sender_ip : query_ip;
			smac_q   <= sender_mac;
			tip_q    <= target_ip;
			oper_q   <= arp_oper;
		end
		if (cmd.step) begin
			if (match_now) begin
				hit_idx_q <= idx_q;
				hit_mac_q <= entry_mac_q[idx_q];
			end
			if (!entry_valid_q[idx_q] && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (cmd.write) begin
			entry_ip_q[wr_idx]  <= key_q;
			entry_mac_q[wr_idx] <= smac_q;
		end
		if (cmd.load) begin
			found_q           <= (opcode_q == OP_LOOKUP) && hit_q;
			found_mac_q       <= ((opcode_q == OP_LOOKUP) && hit_q) ? hit_mac_q : '0;
			packet_ok_q       <= ok_q;
			reply_send_q      <= reply_d;
			reply_dest_mac_q  <= reply_d ? smac_q : '0;
			reply_target_ip_q <= reply_d ? key_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign found_mac       = found_mac_q;
	assign packet_ok       = packet_ok_q;
	assign reply_send      = reply_send_q;
	assign reply_dest_mac  = reply_dest_mac_q;
	assign reply_target_ip = reply_target_ip_q;

endmodule

>>> hw/rtl/arp_cache_with_reply.sv
// Address resolution cache, 16 entries, cleared at reset. A lookup request
// returns the MAC of the first valid entry holding the asked address; a
// received-packet request is checked for length and IPv4 protocol type, its
// sender is learned (update, else first free slot, else slot 0) and a reply
// is flagged when it asks for own_ip. One request at a time: a request goes
// through accept, the single table scan (stopping early on a match), table
// write for packets and result load; a dropped packet skips scan and write.
// The result sits in an output register, so the next request is taken while
// it waits. Registers: own_ip at 0x0, own_mac at 0x8.
module arp_cache_with_reply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [31:0]                 query_ip,
	input  logic [15:0]                 frame_len,
	input  logic [15:0]                 proto_type,
	input  logic [15:0]                 arp_oper,
	input  logic [31:0]                 sender_ip,
	input  logic [47:0]                 sender_mac,
	input  logic [31:0]                 target_ip,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [47:0]                 found_mac,
	output logic                        packet_ok,
	output logic                        reply_send,
	output logic [47:0]                 reply_dest_mac,
	output logic [31:0]                 reply_target_ip
);
	import arpc_pkg::*;

	arpc_cmd_t cmd;
	arpc_sts_t sts;

	assign pready = 1'b1;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.opcode          (opcode),
		.query_ip        (query_ip),
		.frame_len       (frame_len),
		.proto_type      (proto_type),
		.arp_oper        (arp_oper),
		.sender_ip       (sender_ip),
		.sender_mac      (sender_mac),
		.target_ip       (target_ip),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.found_mac       (found_mac),
		.packet_ok       (packet_ok),
		.reply_send      (reply_send),
		.reply_dest_mac  (reply_dest_mac),
		.reply_target_ip (reply_target_ip)
	);

endmodule

>>> hw/rtl/arpc_chk.sv
module arpc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [47:0] found_mac,
	input logic        packet_ok,
	input logic        reply_send,
	input logic [47:0] reply_dest_mac,
	input logic [31:0] reply_target_ip
);

	// held result stays put (found, found_mac, reply_send, reply_dest_mac)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(found_mac)
			&& $stable(reply_send) && $stable(reply_dest_mac))
		else $error("result changed while stalled");

	// one request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !packet_ok && !reply_send)
		else $error("lookup hit mixed with packet result");

	a_reply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_send |-> packet_ok)
		else $error("reply on dropped packet");

	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_send |-> reply_dest_mac == 48'd0 && reply_target_ip == 32'd0)
		else $error("reply fields set without reply");

endmodule

bind arp_cache_with_reply arpc_chk u_arpc_chk (.*);
